[hdl/qte_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg
// Widths, constants, the arctangent table, the CORDIC and rounding functions and
// the pipeline word types that the quaternion to Euler angle converter shares.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int TW            = 35;
	localparam int CW            = 38;
	localparam int ZW            = 28;
	localparam int SW            = 58;
	localparam int SQ_STAGES     = 29;
	localparam int QW            = 18;

	localparam logic signed [TW-1:0] ONE_T     = TW'(1 << 28);
	localparam logic signed [ZW-1:0] PI_Q24    = ZW'(52707179);
	localparam logic signed [QW-1:0] ANGLE_MAX = QW'(25736);
	localparam logic signed [QW-1:0] PITCH_MAX = QW'(12868);

	typedef struct packed {
		logic [SW-1:0]          rem;
		logic [SW-1:0]          root;
		logic signed [TW-1:0]   t0;
		logic signed [TW-1:0]   t1;
		logic signed [TW-1:0]   t2;
		logic signed [TW-1:0]   t3;
		logic signed [TW-1:0]   t4;
	} sqp_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} crd_t;

	function automatic logic signed [ZW-1:0] atan_q24(input int i);
		logic signed [ZW-1:0] a;
		unique case (i)
			0:  a = ZW'(13176795);
			1:  a = ZW'(7778716);
			2:  a = ZW'(4110060);
			3:  a = ZW'(2086331);
			4:  a = ZW'(1047214);
			5:  a = ZW'(524117);
			6:  a = ZW'(262123);
			7:  a = ZW'(131069);
			8:  a = ZW'(65536);
			9:  a = ZW'(32768);
			10: a = ZW'(16384);
			11: a = ZW'(8192);
			12: a = ZW'(4096);
			13: a = ZW'(2048);
			14: a = ZW'(1024);
			15: a = ZW'(512);
			16: a = ZW'(256);
			17: a = ZW'(128);
			18: a = ZW'(64);
			19: a = ZW'(32);
			20: a = ZW'(16);
			21: a = ZW'(8);
			22: a = ZW'(4);
			23: a = ZW'(2);
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic crd_t prerot(input logic signed [TW-1:0] y, input logic signed [TW-1:0] x);
		crd_t c;
		c.x    = CW'(x);
		c.y    = CW'(y);
		c.z    = '0;
		c.zero = (x == '0) && (y == '0);
		if (x < 0) begin
			c.z = (y >= 0) ? PI_Q24 : -PI_Q24;
			c.x = -c.x;
			c.y = -c.y;
		end
		return c;
	endfunction

	function automatic crd_t crd_step(input crd_t c, input int i);
		crd_t r;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		xs = c.x >>> i;
		ys = c.y >>> i;
		r  = c;
		if (c.y >= 0) begin
			r.x = c.x + ys;
			r.y = c.y - xs;
			r.z = c.z + atan_q24(i);
		end else begin
			r.x = c.x - ys;
			r.y = c.y + xs;
			r.z = c.z - atan_q24(i);
		end
		return r;
	endfunction

	function automatic logic signed [QW-1:0] to_q13(input crd_t c, input logic signed [QW-1:0] lim);
		logic signed [ZW:0] z;
		logic signed [ZW:0] m;
		logic signed [QW-1:0] r;
		z = (ZW+1)'(c.z);
		m = (z >= 0) ? z : -z;
		m = (m + (ZW+1)'(1024)) >>> 11;
		r = QW'(m);
		if (z < 0)
			r = -r;
		if (c.zero)
			r = '0;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/quaternion_to_euler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Throughput: one word per cycle; busy is always low and done is never held.
// The pipeline runs through a 29-stage square root and three parallel vectoring CORDICs.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	input  wire logic signed [15:0] quat_w,
	output logic                    done,
	output logic signed [15:0]      roll,
	output logic signed [14:0]      pitch,
	output logic signed [15:0]      yaw
);

	localparam int N = qte_pkg::CORDIC_STAGES;
	localparam int TW = qte_pkg::TW;
	localparam int SW = qte_pkg::SW;
	localparam int SQN = qte_pkg::SQ_STAGES;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [15:0] x_s1, y_s1, z_s1, w_s1;
	logic signed [31:0] xx_s2, yy_s2, zz_s2, xy_s2, wz_s2, wy_s2, xz_s2, yz_s2, wx_s2;
	logic signed [TW-1:0] t0_s3, t1_s3, t2_s3, t3_s3, t4_s3, t2_raw;
	logic [SW-1:0] sq_s4;
	logic signed [TW-1:0] t0_s4, t1_s4, t2_s4, t3_s4, t4_s4;
	logic signed [29:0] t2n;
	logic signed [59:0] t2sq;

	qte_pkg::sqp_t sq_p [0:SQN];
	logic          sq_v [0:SQN];
	qte_pkg::crd_t rl_p [0:N];
	qte_pkg::crd_t pt_p [0:N];
	qte_pkg::crd_t yw_p [0:N];
	logic          cr_v [0:N];

	logic done_q;
	logic signed [15:0] roll_q, yaw_q;
	logic signed [14:0] pitch_q;

	assign busy  = 1'b0;
	assign done  = done_q;
	assign roll  = roll_q;
	assign pitch = pitch_q;
	assign yaw   = yaw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			sq_v[0] <= 1'b0;
			cr_v[0] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			sq_v[0] <= vld_s4;
			cr_v[0] <= sq_v[SQN];
			done_q <= cr_v[N];
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= quat_x;
		y_s1 <= quat_y;
		z_s1 <= quat_z;
		w_s1 <= quat_w;
	end

	always_ff @(posedge clk) begin
		xx_s2 <= x_s1 * x_s1;
		yy_s2 <= y_s1 * y_s1;
		zz_s2 <= z_s1 * z_s1;
		xy_s2 <= x_s1 * y_s1;
		wz_s2 <= w_s1 * z_s1;
		wy_s2 <= w_s1 * y_s1;
		xz_s2 <= x_s1 * z_s1;
		yz_s2 <= y_s1 * z_s1;
		wx_s2 <= w_s1 * x_s1;
	end

	always_comb begin
		t2_raw = (TW'(wy_s2) - TW'(xz_s2)) <<< 1;
		if (t2_raw > qte_pkg::ONE_T)
			t2_raw = qte_pkg::ONE_T;
		if (t2_raw < -qte_pkg::ONE_T)
			t2_raw = -qte_pkg::ONE_T;
	end

	always_ff @(posedge clk) begin
		t0_s3 <= qte_pkg::ONE_T - ((TW'(yy_s2) + TW'(zz_s2)) <<< 1);
		t1_s3 <= (TW'(xy_s2) + TW'(wz_s2)) <<< 1;
		t2_s3 <= t2_raw;
		t3_s3 <= (TW'(yz_s2) + TW'(wx_s2)) <<< 1;
		t4_s3 <= qte_pkg::ONE_T - ((TW'(xx_s2) + TW'(yy_s2)) <<< 1);
	end

	assign t2n  = t2_s3[29:0];
	assign t2sq = t2n * t2n;

	always_ff @(posedge clk) begin
		sq_s4 <= t2sq[SW-1:0];
		t0_s4 <= t0_s3;
		t1_s4 <= t1_s3;
		t2_s4 <= t2_s3;
		t3_s4 <= t3_s3;
		t4_s4 <= t4_s3;
	end

	always_ff @(posedge clk) begin
		sq_p[0].rem  <= (SW'(1) << 56) - sq_s4;
		sq_p[0].root <= '0;
		sq_p[0].t0   <= t0_s4;
		sq_p[0].t1   <= t1_s4;
		sq_p[0].t2   <= t2_s4;
		sq_p[0].t3   <= t3_s4;
		sq_p[0].t4   <= t4_s4;
	end

	for (genvar j = 0; j < SQN; j++) begin : g_sqrt
		localparam logic [SW-1:0] BIT = SW'(1) << (2 * (SQN - 1 - j));
		qte_pkg::sqp_t nx;
		always_comb begin
			nx = sq_p[j];
			if (sq_p[j].rem >= sq_p[j].root + BIT) begin
				nx.rem  = sq_p[j].rem - (sq_p[j].root + BIT);
				nx.root = (sq_p[j].root >> 1) + BIT;
			end else begin
				nx.root = sq_p[j].root >> 1;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v[j+1] <= 1'b0;
			else
				sq_v[j+1] <= sq_v[j];
		end
		always_ff @(posedge clk) begin
			sq_p[j+1] <= nx;
		end
	end

	always_ff @(posedge clk) begin
		pt_p[0] <= qte_pkg::prerot(sq_p[SQN].t2, TW'(sq_p[SQN].root));
		rl_p[0] <= qte_pkg::prerot(sq_p[SQN].t3, sq_p[SQN].t4);
		yw_p[0] <= qte_pkg::prerot(sq_p[SQN].t1, sq_p[SQN].t0);
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cr_v[i+1] <= 1'b0;
			else
				cr_v[i+1] <= cr_v[i];
		end
		always_ff @(posedge clk) begin
			pt_p[i+1] <= qte_pkg::crd_step(pt_p[i], i);
			rl_p[i+1] <= qte_pkg::crd_step(rl_p[i], i);
			yw_p[i+1] <= qte_pkg::crd_step(yw_p[i], i);
		end
	end

	always_ff @(posedge clk) begin
		roll_q  <= 16'(qte_pkg::to_q13(rl_p[N], qte_pkg::ANGLE_MAX));
		pitch_q <= 15'(qte_pkg::to_q13(pt_p[N], qte_pkg::PITCH_MAX));
		yaw_q   <= 16'(qte_pkg::to_q13(yw_p[N], qte_pkg::ANGLE_MAX));
	end

endmodule
`default_nettype wire

[verif/quaternion_to_euler_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_checker
// Watches the command and result channels of the quaternion to Euler angle
// converter, computes the expected roll, pitch and yaw of every accepted word
// in fixed point, and compares each result word with the oldest expected one.
// ----------------------------------------------------------------------------
module quaternion_to_euler_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	input  wire logic signed [15:0] quat_w,
	input  wire logic               done,
	input  wire logic signed [15:0] roll,
	input  wire logic signed [14:0] pitch,
	input  wire logic signed [15:0] yaw,
	output int                      errors,
	output int                      pending
);

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
	} angles_t;

	localparam longint ONE = 64'sd1 <<< 28;
	localparam longint PI_ANGLE = 64'sd52707179;

	angles_t angle_queue[$];

	function automatic longint arctan_step(input int i);
		longint table_q24[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
			262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		return table_q24[i];
	endfunction

	function automatic longint vector_angle(input longint yv, input longint xv);
		longint ang;
		longint xs;
		longint ys;
		ang = 0;
		if (xv == 0 && yv == 0)
			return 0;
		if (xv < 0) begin
			ang = (yv >= 0) ? PI_ANGLE : -PI_ANGLE;
			xv = -xv;
			yv = -yv;
		end
		for (int i = 0; i < qte_pkg::CORDIC_STAGES; i++) begin
			xs = xv >>> i;
			ys = yv >>> i;
			if (yv >= 0) begin
				xv += ys;
				yv -= xs;
				ang += arctan_step(i);
			end else begin
				xv -= ys;
				yv += xs;
				ang -= arctan_step(i);
			end
		end
		return ang;
	endfunction

	function automatic longint round_sat(input longint ang, input longint lim);
		longint r;
		r = (ang >= 0) ? ((ang + 1024) >>> 11) : -(((-ang) + 1024) >>> 11);
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic longint int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic angles_t euler_angles(input longint x, input longint y,
			input longint z, input longint w);
		angles_t a;
		longint t0;
		longint t1;
		longint t2;
		longint t3;
		longint t4;
		longint c;
		t0 = ONE - 2 * (y * y + z * z);
		t1 = 2 * (x * y + w * z);
		t2 = 2 * (w * y - x * z);
		t3 = 2 * (y * z + w * x);
		t4 = ONE - 2 * (x * x + y * y);
		if (t2 > ONE)
			t2 = ONE;
		if (t2 < -ONE)
			t2 = -ONE;
		c = int_sqrt(longint'(ONE * ONE) - t2 * t2);
		a.pitch = 15'(round_sat(vector_angle(t2, c), 12868));
		a.roll = 16'(round_sat(vector_angle(t3, t4), 25736));
		a.yaw = 16'(round_sat(vector_angle(t1, t0), 25736));
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		angles_t exp_word;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (done) begin
				if (angle_queue.size() == 0) begin
					$display("%0t: unexpected word roll %0d pitch %0d yaw %0d",
						$time, roll, pitch, yaw);
					errors <= errors + 1;
				end else begin
					exp_word = angle_queue.pop_front();
					if (exp_word != {roll, pitch, yaw}) begin
						$display("%0t: expected roll %0d pitch %0d yaw %0d, got %0d %0d %0d",
							$time, exp_word.roll, exp_word.pitch, exp_word.yaw,
							roll, pitch, yaw);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy)
				angle_queue.push_back(euler_angles(quat_x, quat_y, quat_z, quat_w));
		end
	end

	assign pending = angle_queue.size();

endmodule

[verif/tb_quaternion_to_euler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler
// Drives directed and random quaternions into the converter under several
// idle patterns and reports the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [15:0] quat_x = '0;
	logic signed [15:0] quat_y = '0;
	logic signed [15:0] quat_z = '0;
	logic signed [15:0] quat_w = '0;
	logic               busy;
	logic               done;
	logic signed [15:0] roll;
	logic signed [14:0] pitch;
	logic signed [15:0] yaw;
	int                 errors;
	int                 pending;
	int                 cycles = 0;
	int                 idle_pct = 0;

	always #6 clk = ~clk;

	quaternion_to_euler i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.done(done), .roll(roll), .pitch(pitch), .yaw(yaw)
	);

	quaternion_to_euler_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.done(done), .roll(roll), .pitch(pitch), .yaw(yaw),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("tb_quaternion_to_euler: errors");
			$finish;
		end
	end

	function automatic logic signed [15:0] component(input int mode);
		case (mode)
			0: return 16'($urandom_range(32767) - 16384);
			1: return 16'($urandom);
			default: return 16'($urandom_range(1000) - 500);
		endcase
	endfunction

	// send one word, with an optional random gap before it
	task automatic send(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic signed [15:0] z, input logic signed [15:0] w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		quat_x <= x;
		quat_y <= y;
		quat_z <= z;
		quat_w <= w;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		int mode;
		int drain;
		int s;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// identity, axis turns, extremes, gimbal lock, zero and non-unit codes
		send(0, 0, 0, 16384);
		send(16384, 0, 0, 0);
		send(0, 16384, 0, 0);
		send(0, 0, 16384, 0);
		send(-16384, 0, 0, 0);
		send(0, -16384, 0, 0);
		send(0, 0, -16384, 0);
		send(0, 0, 0, -16384);
		send(11585, 0, 0, 11585);
		send(0, 11585, 0, 11585);
		send(0, -11585, 0, 11585);
		send(0, 0, 11585, 11585);
		send(0, 0, 0, 0);
		send(16384, 16384, 16384, 16384);
		send(-16384, -16384, -16384, -16384);
		send(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send(8192, 8192, 8192, 8192);
		send(8192, -8192, 8192, -8192);
		send(1, 0, 0, 0);
		send(0, -1, 0, 1);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 75 : (ph == 3) ? 37 : 0;
			for (int i = 0; i < 400; i++) begin
				s = $urandom_range(9);
				mode = (s < 7) ? 0 : (s < 9) ? 1 : 2;
				send(component(mode), component(mode), component(mode), component(mode));
			end
		end
		start <= 1'b0;
		drain = 0;
		while (pending != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_quaternion_to_euler: clean");
		else
			$display("tb_quaternion_to_euler: errors");
		$finish;
	end

endmodule
